FILE: hdl/m68k_old_pkg.sv
// Package for the 68000 opcode length decoder: transfer structs, operation
// numbers, size codes, opcode masks and the effective-address word count.
// Depends on nothing; used by hdl/m68k_opcode_length_decoder.sv.
package m68k_old_pkg;

    typedef struct packed {
        logic [15:0] opcode_word;
        logic [15:0] ext_word_one;
        logic [15:0] ext_word_two;
    } m68k_old_cmd_t;

    typedef struct packed {
        logic               recognized;
        logic [5:0]         op_id;
        logic [1:0]         size_code;
        logic [2:0]         length_words;
        logic               has_displacement;
        logic signed [31:0] branch_disp;
    } m68k_old_result_t;

    // Operand size codes.
    localparam logic [1:0] SZ_NONE = 2'd0;
    localparam logic [1:0] SZ_BYTE = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_LONG = 2'd3;

    // Operation numbers in decode-tree order.
    localparam logic [5:0] OP_NONE    = 6'd0;
    localparam logic [5:0] OP_ORI     = 6'd1;
    localparam logic [5:0] OP_SUBI    = 6'd2;
    localparam logic [5:0] OP_ADDI    = 6'd3;
    localparam logic [5:0] OP_MOVE_B  = 6'd4;
    localparam logic [5:0] OP_MOVEA_L = 6'd5;
    localparam logic [5:0] OP_MOVE_L  = 6'd6;
    localparam logic [5:0] OP_MOVEA_W = 6'd7;
    localparam logic [5:0] OP_MOVE_W  = 6'd8;
    localparam logic [5:0] OP_CLR     = 6'd9;
    localparam logic [5:0] OP_LEA     = 6'd10;
    localparam logic [5:0] OP_RTR     = 6'd11;
    localparam logic [5:0] OP_NOP     = 6'd12;
    localparam logic [5:0] OP_RTS     = 6'd13;
    localparam logic [5:0] OP_JMP     = 6'd14;
    localparam logic [5:0] OP_NOT     = 6'd15;
    localparam logic [5:0] OP_TRAP    = 6'd16;
    localparam logic [5:0] OP_DBHI    = 6'd17;
    localparam logic [5:0] OP_SUBQ    = 6'd31;
    localparam logic [5:0] OP_ADDQ    = 6'd32;
    localparam logic [5:0] OP_BRA     = 6'd33;
    localparam logic [5:0] OP_BHI     = 6'd34;
    localparam logic [5:0] OP_MOVEQ   = 6'd48;
    localparam logic [5:0] OP_OR      = 6'd49;
    localparam logic [5:0] OP_SUBX    = 6'd50;
    localparam logic [5:0] OP_SUBA    = 6'd51;
    localparam logic [5:0] OP_SUB     = 6'd52;
    localparam logic [5:0] OP_CMP     = 6'd53;
    localparam logic [5:0] OP_MULU    = 6'd54;
    localparam logic [5:0] OP_MULS    = 6'd55;
    localparam logic [5:0] OP_ADD     = 6'd56;
    localparam logic [5:0] OP_ADDX    = 6'd57;
    localparam logic [5:0] OP_ADDA    = 6'd58;

    // Condition codes that need special handling.
    localparam logic [3:0] CC_TRUE  = 4'h0;
    localparam logic [3:0] CC_FALSE = 4'h1;
    localparam logic [3:0] CC_HI    = 4'h2;

    // Opcode masks and match patterns.
    localparam logic [15:0] MASK_HI_BYTE  = 16'hFF00;
    localparam logic [15:0] MASK_OPMODE   = 16'h01C0;
    localparam logic [15:0] MASK_LEA      = 16'hF1C0;
    localparam logic [15:0] MASK_DBCC     = 16'hF0F8;
    localparam logic [15:0] MASK_QUICK    = 16'hF100;
    localparam logic [15:0] MASK_SUBX     = 16'hF130;
    localparam logic [15:0] MASK_JMP      = 16'hFFC0;
    localparam logic [15:0] MASK_TRAP     = 16'hFFF0;
    localparam logic [15:0] MASK_ADDX     = 16'hD100;
    localparam logic [15:0] PAT_ORI       = 16'h0000;
    localparam logic [15:0] PAT_SUBI      = 16'h0400;
    localparam logic [15:0] PAT_ADDI      = 16'h0600;
    localparam logic [15:0] PAT_MOVEA     = 16'h0040;
    localparam logic [15:0] PAT_CLR       = 16'h4200;
    localparam logic [15:0] PAT_LEA       = 16'h41C0;
    localparam logic [15:0] PAT_RTR       = 16'h4E77;
    localparam logic [15:0] PAT_NOP       = 16'h4E71;
    localparam logic [15:0] PAT_RTS       = 16'h4E75;
    localparam logic [15:0] PAT_JMP       = 16'h4E00;
    localparam logic [15:0] PAT_NOT       = 16'h4600;
    localparam logic [15:0] PAT_TRAP      = 16'h4E40;
    localparam logic [15:0] PAT_DBCC      = 16'h50C8;
    localparam logic [15:0] PAT_SUBQ      = 16'h5100;
    localparam logic [15:0] PAT_MOVEQ     = 16'h7000;
    localparam logic [15:0] PAT_SUBX      = 16'h9100;
    localparam logic [15:0] PAT_MULU      = 16'hC0C0;
    localparam logic [15:0] PAT_MULS      = 16'hC1C0;
    localparam logic [15:0] PAT_ADDX      = 16'hD100;

    // Effective-address modes and the mode-7 registers that matter.
    localparam logic [2:0] EA_MODE_DISP  = 3'd5;
    localparam logic [2:0] EA_MODE_INDEX = 3'd6;
    localparam logic [2:0] EA_MODE_EXT   = 3'd7;
    localparam logic [2:0] EA_REG_ABS_W  = 3'd0;
    localparam logic [2:0] EA_REG_IMM    = 3'd4;

    // Branch low-byte markers.
    localparam logic [7:0] BR_WORD = 8'h00;
    localparam logic [7:0] BR_LONG = 8'hFF;

    // Size field of the opcode to size code; the reserved value gives none.
    function automatic logic [1:0] size_from_field(input logic [1:0] f);
        logic [1:0] code;
        code = (f == 2'd3) ? SZ_NONE : f + 2'd1;
        return code;
    endfunction

    // Extension words that an effective address adds, for an operand size.
    function automatic logic [1:0] ea_words(input logic [2:0] mode, input logic [2:0] rn,
                                            input logic [1:0] sz);
        logic [1:0] words;
        words = 2'd0;
        if (mode == EA_MODE_DISP || mode == EA_MODE_INDEX) begin
            words = 2'd1;
        end else if (mode == EA_MODE_EXT) begin
            if (rn == EA_REG_ABS_W) begin
                words = 2'd1;
            end else if (rn == EA_REG_IMM) begin
                if (sz == SZ_LONG) begin
                    words = 2'd2;
                end else if (sz == SZ_NONE) begin
                    words = 2'd0;
                end else begin
                    words = 2'd1;
                end
            end else begin
                words = 2'd2;
            end
        end
        return words;
    endfunction

endpackage

FILE: hdl/m68k_opcode_length_decoder.sv
// Top level of the 68000 opcode length decoder: input register, decode tree
// and result register. Depends on hdl/m68k_old_pkg.sv.
//
//  Channel   Signals                      Direction  Transfer when
//  command   start, busy, cmd             in         start high and busy low at clk rise
//  result    done, result                 out        every cycle in which done is high
//
// Each transfer is captured in an input register; the decode tree sits between
// that register and the result register, so each command passes through both
// registers before its result appears, and done marks each result.
// One command is taken every cycle: busy is always low, and the rate is set by
// the single decode pass between the two registers.
// Reset clears the valid flags of both stages; payload registers are not reset.
// The receiver cannot stall, so no result ever waits and nothing is dropped.
module m68k_opcode_length_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  m68k_old_pkg::m68k_old_cmd_t     cmd,
    output logic                            done,
    output m68k_old_pkg::m68k_old_result_t  result
);

    m68k_old_pkg::m68k_old_cmd_t    cmd_reg;
    logic                           valid_reg;
    m68k_old_pkg::m68k_old_result_t result_reg;
    m68k_old_pkg::m68k_old_result_t result_next;
    logic                           done_reg;

    // Decode is combinational and never stalls, so the block never holds commands off.
    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Stage one: capture the command words on a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            cmd_reg <= cmd;
        end
    end

    // Decode tree. The top nibble picks the instruction line; within each
    // line the tests run in priority order and the first match wins.
    always_comb
    begin
        logic [15:0] op;
        logic [2:0]  sm;
        logic [2:0]  sr;
        logic [2:0]  dm;
        logic [2:0]  dr;
        logic [1:0]  sf;
        logic [3:0]  cc;
        logic [5:0]  id;
        logic [1:0]  sc;
        logic [2:0]  len;
        logic        hd;
        logic [31:0] disp;

        op   = cmd_reg.opcode_word;
        sm   = op[5:3];
        sr   = op[2:0];
        dm   = op[8:6];
        dr   = op[11:9];
        sf   = op[7:6];
        cc   = op[11:8];
        id   = m68k_old_pkg::OP_NONE;
        sc   = m68k_old_pkg::SZ_NONE;
        len  = 3'd1;
        hd   = 1'b0;
        disp = 32'd0;

        case (op[15:12])
            4'h0:
            begin
                if ((op & m68k_old_pkg::MASK_HI_BYTE) == m68k_old_pkg::PAT_ORI) begin
                    id = m68k_old_pkg::OP_ORI;
                    sc = m68k_old_pkg::size_from_field(sf);
                    if (sc != m68k_old_pkg::SZ_NONE) begin
                        len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, sc)};
                    end
                end else if ((op & m68k_old_pkg::MASK_HI_BYTE) == m68k_old_pkg::PAT_SUBI) begin
                    id = m68k_old_pkg::OP_SUBI;
                    sc = m68k_old_pkg::size_from_field(sf);
                    if (sc != m68k_old_pkg::SZ_NONE) begin
                        // The immediate itself takes two words for a long operand.
                        len = len + ((sc == m68k_old_pkg::SZ_LONG) ? 3'd2 : 3'd1)
                              + {1'b0, m68k_old_pkg::ea_words(sm, sr, sc)};
                    end
                end else if ((op & m68k_old_pkg::MASK_HI_BYTE) == m68k_old_pkg::PAT_ADDI) begin
                    id  = m68k_old_pkg::OP_ADDI;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
                end
            end
            4'h1:
            begin
                id  = m68k_old_pkg::OP_MOVE_B;
                sc  = m68k_old_pkg::SZ_BYTE;
                len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)}
                      + {1'b0, m68k_old_pkg::ea_words(dm, dr, m68k_old_pkg::SZ_BYTE)};
            end
            4'h2:
            begin
                sc = m68k_old_pkg::SZ_LONG;
                if ((op & m68k_old_pkg::MASK_OPMODE) == m68k_old_pkg::PAT_MOVEA) begin
                    id  = m68k_old_pkg::OP_MOVEA_L;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_LONG)};
                end else begin
                    id  = m68k_old_pkg::OP_MOVE_L;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_LONG)}
                          + {1'b0, m68k_old_pkg::ea_words(dm, dr, m68k_old_pkg::SZ_LONG)};
                end
            end
            4'h3:
            begin
                sc = m68k_old_pkg::SZ_WORD;
                if ((op & m68k_old_pkg::MASK_OPMODE) == m68k_old_pkg::PAT_MOVEA) begin
                    // movea.w counts its source words as a byte operand does.
                    id  = m68k_old_pkg::OP_MOVEA_W;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
                end else begin
                    id  = m68k_old_pkg::OP_MOVE_W;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_WORD)}
                          + {1'b0, m68k_old_pkg::ea_words(dm, dr, m68k_old_pkg::SZ_WORD)};
                end
            end
            4'h4:
            begin
                if ((op & m68k_old_pkg::MASK_HI_BYTE) == m68k_old_pkg::PAT_CLR) begin
                    id = m68k_old_pkg::OP_CLR;
                    sc = m68k_old_pkg::size_from_field(sf);
                    if (sc != m68k_old_pkg::SZ_NONE) begin
                        len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, sc)};
                    end
                end else if ((op & m68k_old_pkg::MASK_LEA) == m68k_old_pkg::PAT_LEA) begin
                    id  = m68k_old_pkg::OP_LEA;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
                end else if (op == m68k_old_pkg::PAT_RTR) begin
                    id = m68k_old_pkg::OP_RTR;
                end else if (op == m68k_old_pkg::PAT_NOP) begin
                    id = m68k_old_pkg::OP_NOP;
                end else if (op == m68k_old_pkg::PAT_RTS) begin
                    id = m68k_old_pkg::OP_RTS;
                end else if ((op & m68k_old_pkg::MASK_JMP) == m68k_old_pkg::PAT_JMP) begin
                    id  = m68k_old_pkg::OP_JMP;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
                end else if (op == m68k_old_pkg::PAT_NOT) begin
                    id = m68k_old_pkg::OP_NOT;
                end else if ((op & m68k_old_pkg::MASK_TRAP) == m68k_old_pkg::PAT_TRAP) begin
                    id = m68k_old_pkg::OP_TRAP;
                end
            end
            4'h5:
            begin
                if ((op & m68k_old_pkg::MASK_DBCC) == m68k_old_pkg::PAT_DBCC) begin
                    // DBT and DBF are left unrecognized.
                    if (cc >= m68k_old_pkg::CC_HI) begin
                        id  = m68k_old_pkg::OP_DBHI + {2'b00, cc - m68k_old_pkg::CC_HI};
                        len = 3'd2;
                    end
                end else if ((op & m68k_old_pkg::MASK_QUICK) == m68k_old_pkg::PAT_SUBQ) begin
                    id  = m68k_old_pkg::OP_SUBQ;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
                end else begin
                    id = m68k_old_pkg::OP_ADDQ;
                    sc = m68k_old_pkg::size_from_field(sf);
                    if (sc != m68k_old_pkg::SZ_NONE) begin
                        len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, sc)};
                    end
                end
            end
            4'h6:
            begin
                // The BSR encoding is left unrecognized.
                if (cc != m68k_old_pkg::CC_FALSE) begin
                    id = (cc == m68k_old_pkg::CC_TRUE) ? m68k_old_pkg::OP_BRA
                         : m68k_old_pkg::OP_BHI + {2'b00, cc - m68k_old_pkg::CC_HI};
                    hd = 1'b1;
                    if (op[7:0] == m68k_old_pkg::BR_WORD) begin
                        sc   = m68k_old_pkg::SZ_WORD;
                        len  = 3'd2;
                        disp = {{16{cmd_reg.ext_word_one[15]}}, cmd_reg.ext_word_one};
                    end else if (op[7:0] == m68k_old_pkg::BR_LONG) begin
                        sc   = m68k_old_pkg::SZ_LONG;
                        len  = 3'd3;
                        disp = {cmd_reg.ext_word_one, cmd_reg.ext_word_two};
                    end else begin
                        disp = {{24{op[7]}}, op[7:0]};
                    end
                end
            end
            4'h7:
            begin
                if ((op & m68k_old_pkg::MASK_QUICK) == m68k_old_pkg::PAT_MOVEQ) begin
                    id = m68k_old_pkg::OP_MOVEQ;
                end
            end
            4'h8:
            begin
                id  = m68k_old_pkg::OP_OR;
                len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
            end
            4'h9:
            begin
                if ((op & m68k_old_pkg::MASK_SUBX) == m68k_old_pkg::PAT_SUBX) begin
                    id = m68k_old_pkg::OP_SUBX;
                end else if (dm inside {3'd3, 3'd7}) begin
                    id  = m68k_old_pkg::OP_SUBA;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
                end else begin
                    id = m68k_old_pkg::OP_SUB;
                    sc = m68k_old_pkg::size_from_field(dm[1:0]);
                    if (sc != m68k_old_pkg::SZ_NONE) begin
                        len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, sc)};
                    end
                end
            end
            4'hB:
            begin
                id = m68k_old_pkg::OP_CMP;
                sc = m68k_old_pkg::size_from_field(sf);
                if (sc != m68k_old_pkg::SZ_NONE) begin
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, sc)};
                end
            end
            4'hC:
            begin
                if ((op & m68k_old_pkg::MASK_LEA) == m68k_old_pkg::PAT_MULU) begin
                    id = m68k_old_pkg::OP_MULU;
                    sc = m68k_old_pkg::SZ_WORD;
                end else if ((op & m68k_old_pkg::MASK_LEA) == m68k_old_pkg::PAT_MULS) begin
                    id = m68k_old_pkg::OP_MULS;
                    sc = m68k_old_pkg::SZ_WORD;
                end else begin
                    id = m68k_old_pkg::OP_ADD;
                end
                len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
            end
            4'hD:
            begin
                if ((op & m68k_old_pkg::MASK_ADDX) == m68k_old_pkg::PAT_ADDX) begin
                    id = m68k_old_pkg::OP_ADDX;
                end else begin
                    id  = m68k_old_pkg::OP_ADDA;
                    len = len + {1'b0, m68k_old_pkg::ea_words(sm, sr, m68k_old_pkg::SZ_BYTE)};
                end
            end
            default:
            begin
                id = m68k_old_pkg::OP_NONE;
            end
        endcase

        result_next.recognized       = (id != m68k_old_pkg::OP_NONE);
        result_next.op_id            = id;
        result_next.size_code        = sc;
        result_next.length_words     = len;
        result_next.has_displacement = hd;
        result_next.branch_disp      = disp;
    end

    // Stage two: register the decoded result and raise done with it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg) begin
            result_reg <= result_next;
        end
    end

    // Every captured command yields exactly one result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> done)
        else $error("captured command did not produce a result");

    // A command transfer shows up as a result after the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("result missing two cycles after command transfer");

    // Length is always between one and five words.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.length_words >= 3'd1 && result.length_words <= 3'd5))
        else $error("instruction length out of range");

    // An unrecognized opcode reports no operation, no size and a single word.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.recognized |-> (result.op_id == m68k_old_pkg::OP_NONE
            && result.size_code == m68k_old_pkg::SZ_NONE && result.length_words == 3'd1
            && !result.has_displacement))
        else $error("unrecognized opcode with non-default result fields");

    // Only branches carry a displacement.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.has_displacement |-> result.branch_disp == 32'sd0)
        else $error("displacement reported for a non-branch");

endmodule
